/* hw/rtl/assert_macros.svh */
// assertion helpers for the rtl, clocked on aclk and idle while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/crc32s_pkg.sv */
package crc32s_pkg;

    localparam int unsigned CRC_W      = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [CRC_W-1:0] POLY_RESET = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] CRC_MSB    = 32'h8000_0000;

    // register index, taken from the word address bit
    typedef enum logic {
        REG_POLY = 1'b0
    } reg_idx_t;

    // eight msb-first reduction steps on the byte leaving the top of the register
    function automatic logic [CRC_W-1:0] reduce_byte(input logic [BYTE_W-1:0] top,
                                                     input logic [CRC_W-1:0]  poly);
        logic [CRC_W-1:0] acc;
        acc = {top, 24'h00_0000};
        for (int k = 0; k < BYTE_W; k++) begin
            if ((acc & CRC_MSB) != '0) begin
                acc = {acc[CRC_W-2:0], 1'b0} ^ poly;
            end else begin
                acc = {acc[CRC_W-2:0], 1'b0};
            end
        end
        return acc;
    endfunction

endpackage

/* hw/rtl/crc32_msb_first_stream_unit.sv */
// byte-stream crc-32, msb first, no zero augmentation
// input stream: s_tdata carries one message byte, s_tlast marks the final byte
// of a message; every message holds at least one byte
// output stream: one 32-bit crc in m_tdata per message, after its final byte
// config: apb register 0 (byte address 0) holds the generator polynomial with
// the top bit implicit, 0x04c11db7 after reset; write it only between messages
// the first four bytes are packed into the crc register and then inverted,
// later bytes shift in at the bottom while the byte leaving the top is reduced
// throughput: one byte per clock, set by the single-cycle byte update of the
// crc register through an eight-step xor network
// latency: the crc appears on m_tdata one cycle after the edge that accepts the
// final byte request (input register, then result register)
// stall: while m_tready is low the result is held; mid-message bytes still flow,
// and a final byte waits in the input register, which then drops s_tready
// reset: synchronous, active low; clears the crc state, byte count, both
// valid flags and restores the default polynomial
`include "assert_macros.svh"

module crc32_msb_first_stream_unit
    import crc32s_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // stream in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // last_byte
    // stream out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [CRC_W-1:0]      m_tdata,   // [31:0] crc_value
    // apb config
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_last_reg;
    logic              out_valid_reg, out_valid_next;
    logic [CRC_W-1:0]  out_data_reg;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CRC_W-1:0]  poly_reg;

    logic              out_free;
    logic              proceed;
    logic              in_take;
    logic              cfg_write;
    logic [CRC_W-1:0]  crc_upd;
    logic [CNT_W-1:0]  cnt_upd;
    logic [CRC_W-1:0]  packed_byte;
    logic [CRC_W-1:0]  result;

    // ---------------- handshake ----------------
    assign out_free = !out_valid_reg || m_tready;
    // a final byte only moves on when the result register can take its crc
    assign proceed  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || proceed;
    assign in_take  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- config ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (reg_idx_t'(paddr[2]) == REG_POLY);

    always_comb begin
        unique case (reg_idx_t'(paddr[2]))
            REG_POLY: prdata = poly_reg;
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg <= POLY_RESET;
        end else if (cfg_write) begin
            poly_reg <= pwdata;
        end
    end

    // ---------------- byte update ----------------
    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    packed_byte = {in_data_reg, 24'h00_0000};
            2'd1:    packed_byte = {8'h00, in_data_reg, 16'h0000};
            2'd2:    packed_byte = {16'h0000, in_data_reg, 8'h00};
            default: packed_byte = {24'h00_0000, in_data_reg};
        endcase
    end

    always_comb begin
        if (!cnt_reg[2]) begin
            cnt_upd = cnt_reg + 3'd1;
            // fourth byte packed: invert the register
            if (cnt_reg[1:0] == 2'd3) begin
                crc_upd = ~(crc_reg | packed_byte);
            end else begin
                crc_upd = crc_reg | packed_byte;
            end
        end else begin
            cnt_upd = cnt_reg;
            crc_upd = {crc_reg[CRC_W-BYTE_W-1:0], in_data_reg}
                      ^ reduce_byte(crc_reg[CRC_W-1:CRC_W-BYTE_W], poly_reg);
        end
        // short messages leave the register uninverted
        result = cnt_upd[2] ? ~crc_upd : crc_upd;
    end

    always_comb begin
        crc_next       = crc_reg;
        cnt_next       = cnt_reg;
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (proceed) begin
            in_valid_next = 1'b0;
            if (in_last_reg) begin
                crc_next       = '0;
                cnt_next       = '0;
                out_valid_next = 1'b1;
            end else begin
                crc_next = crc_upd;
                cnt_next = cnt_upd;
            end
        end
        if (in_take) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= '0;
            cnt_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            crc_reg       <= crc_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (proceed && in_last_reg) begin
            out_data_reg <= result;
        end
    end

    // ---------------- checks ----------------
    `ASSERT_IMPLIES(a_cnt_range, 1'b1, cnt_reg <= 3'd4, "byte count beyond four")
    `ASSERT_IMPLIES(a_no_overwrite, proceed && in_last_reg, out_free,
                    "crc overwrites a result not yet taken")
    `ASSERT_NEXT(a_clear_after_last, proceed && in_last_reg,
                 (crc_reg == '0) && (cnt_reg == '0), "state not cleared after final byte")
    `ASSERT_NEXT(a_fourth_byte, proceed && !in_last_reg && (cnt_reg == 3'd3),
                 cnt_reg == 3'd4, "fourth byte did not complete packing")

endmodule
